// ===== hw/rtl/kmer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_pkg: shared types and constants
// Item structs, status codes, sequencer states and FNV-1a constants.
// ----------------------------------------------------------------------------
package kmer_pkg;

  localparam int unsigned CODE_W  = 63;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned K_W     = 5;
  localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] HASH_MULT  = 64'h00000100000001B3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_FILLING  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_READOUT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RDOUT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  symbol;
    logic        last_of_read;
    logic [15:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  kmer_code;
    logic [COUNT_W-1:0] count;
    logic               entry_present;
    logic [2:0]         status;
  } out_item_t;

  function automatic logic [7:0] code_ascii(input logic [2:0] c);
    case (c)
      3'd0:    code_ascii = 8'h41;
      3'd1:    code_ascii = 8'h43;
      3'd2:    code_ascii = 8'h47;
      3'd3:    code_ascii = 8'h54;
      default: code_ascii = 8'h4E;
    endcase
  endfunction

endpackage

// ===== hw/rtl/kmer_hash_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_hash_unit: iterative FNV-1a round unit
// One 64-bit multiply round per step, built from three 32x32 partial products.
// ----------------------------------------------------------------------------
module kmer_hash_unit (
  input  logic        clk,
  input  logic        init,
  input  logic        step,
  input  logic [7:0]  byte_in,
  output logic [63:0] hash,
  output logic        ready
);
  import kmer_pkg::*;

  // phase 0: xor byte, 1..2: partial products, 3: sum
  logic [63:0] h_r, h_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] p_lo_r, p_lo_nxt;
  logic [31:0] p_mid_r, p_mid_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    h_nxt     = h_r;
    x_nxt     = x_r;
    p_lo_nxt  = p_lo_r;
    p_mid_nxt = p_mid_r;
    ph_nxt    = ph_r;
    busy_nxt  = busy_r;
    if (init) begin
      h_nxt    = HASH_BASIS;
      busy_nxt = 1'b0;
    end else if (step && !busy_r) begin
      x_nxt    = h_r ^ {56'd0, byte_in};
      ph_nxt   = 2'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (ph_r)
        2'd1: begin
          p_lo_nxt = x_r[31:0] * HASH_MULT[31:0];
          ph_nxt   = 2'd2;
        end
        2'd2: begin
          p_mid_nxt = x_r[31:0] * HASH_MULT[63:32] + x_r[63:32] * HASH_MULT[31:0];
          ph_nxt    = 2'd3;
        end
        default: begin
          h_nxt    = p_lo_r + {p_mid_r, 32'd0};
          busy_nxt = 1'b0;
          ph_nxt   = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    x_r     <= x_nxt;
    p_lo_r  <= p_lo_nxt;
    p_mid_r <= p_mid_nxt;
    ph_r    <= ph_nxt;
    busy_r  <= busy_nxt;
  end

  assign hash  = h_r;
  assign ready = !busy_r;

endmodule

// ===== hw/rtl/kmer_counter_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_counter_hash_table: k-mer counter over an FNV-1a linear-probed table
// Filling and invalid items go straight to the result, readout reads the slot first,
// and a full window hashes its k symbols, then does one read and check per probe.
// One item at a time; busy stays high until the result strobe.
// Reset clears control state, then a clearing pass over all TABLE_SLOTS slots
// empties the used bits; busy is high during the pass.
// ----------------------------------------------------------------------------
module kmer_counter_hash_table #(
  parameter int unsigned TABLE_SLOTS = 65536,
  parameter int unsigned MAX_K       = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kmer_pkg::in_item_t  in_item,
  output logic                out_valid,
  output kmer_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import kmer_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);

  logic [CODE_W-1:0]  key_mem [TABLE_SLOTS];
  logic [COUNT_W-1:0] cnt_mem [TABLE_SLOTS];
  logic               used_mem [TABLE_SLOTS];

  fsm_t state_r, state_nxt;
  logic [K_W-1:0]    k_r;
  logic [CODE_W-1:0] win_r, win_nxt;
  logic [K_W-1:0]    fill_r, fill_nxt;
  logic              bad_r, bad_nxt;
  logic [AW:0]       occ_r, occ_nxt;
  logic [AW:0]       clr_r;
  logic              clearing_r;
  in_item_t          item_r;
  logic [K_W-1:0]    hcnt_r, hcnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW:0]       pcnt_r, pcnt_nxt;
  out_item_t         res_r, res_nxt;
  logic              ov_r, ov_nxt;
  logic [CODE_W-1:0] rd_key_r;
  logic [COUNT_W-1:0] rd_cnt_r;
  logic              rd_used_r;
  logic              wr_en;
  logic [COUNT_W-1:0] wr_cnt;
  logic              wr_new;

  logic              h_init, h_step, h_ready;
  logic [63:0]       h_val;
  logic [2:0]        cur_code;
  logic [2:0]        bcode;
  logic              bvalid;
  logic [5:0]        sh;
  logic [CODE_W-1:0] kmask;
  logic [CODE_W-1:0] win_shift;
  logic              accept;

  kmer_hash_unit u_hash (
    .clk(clk), .init(h_init), .step(h_step), .byte_in(code_ascii(cur_code)),
    .hash(h_val), .ready(h_ready)
  );

  assign accept = start && !busy;
  assign busy   = clearing_r || (state_r != S_IDLE);

  always_comb begin
    bvalid = 1'b1;
    case (in_item.symbol)
      8'h41:   bcode = 3'd0;
      8'h43:   bcode = 3'd1;
      8'h47:   bcode = 3'd2;
      8'h54:   bcode = 3'd3;
      8'h4E:   bcode = 3'd4;
      default: begin bcode = 3'd0; bvalid = 1'b0; end
    endcase
  end

  always_comb begin
    kmask = '0;
    for (int i = 0; i < 21; i++) begin
      if (i < k_r) kmask[3*i +: 3] = 3'b111;
    end
  end

  assign win_shift = ((win_r << 3) | {60'd0, bcode}) & kmask;
  assign sh        = 6'(3 * (hcnt_r - 5'd1));
  assign cur_code  = 3'(win_r >> sh);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.mode) state_nxt = S_RDOUT;
          else if (bad_r || !bvalid) state_nxt = S_DONE;
          else if (fill_r + 5'd1 >= k_r || fill_r >= k_r) state_nxt = S_HASH;
          else state_nxt = S_DONE;
        end
      end
      S_HASH:      if (hcnt_r == '0 && h_ready) state_nxt = S_PROBE_RD;
      S_PROBE_RD:  state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!rd_used_r || rd_key_r == win_r || pcnt_r == (AW+1)'(TABLE_SLOTS - 1))
          state_nxt = S_DONE;
        else state_nxt = S_PROBE_RD;
      end
      S_RDOUT:     state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    bad_nxt  = bad_r;
    occ_nxt  = occ_r;
    hcnt_nxt = hcnt_r;
    idx_nxt  = idx_r;
    pcnt_nxt = pcnt_r;
    res_nxt  = res_r;
    ov_nxt   = 1'b0;
    h_init   = 1'b0;
    h_step   = 1'b0;
    wr_en    = 1'b0;
    wr_new   = 1'b0;
    wr_cnt   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && !in_item.mode) begin
          if (bad_r || !bvalid) begin
            bad_nxt = 1'b1;
            res_nxt = '{kmer_code: '0, count: '0, entry_present: 1'b0, status: ST_INVALID};
          end else begin
            win_nxt = win_shift;
            if (fill_r < k_r) fill_nxt = fill_r + 5'd1;
            res_nxt = '{kmer_code: win_shift, count: '0, entry_present: 1'b0,
                        status: ST_FILLING};
            h_init   = 1'b1;
            hcnt_nxt = k_r;
          end
        end
      end
      S_HASH: begin
        if (hcnt_r != '0 && h_ready) begin
          h_step   = 1'b1;
          hcnt_nxt = hcnt_r - 5'd1;
        end else if (hcnt_r == '0 && h_ready) begin
          idx_nxt  = h_val[AW-1:0];
          pcnt_nxt = '0;
        end
      end
      S_PROBE_CHK: begin
        if (!rd_used_r) begin
          if (occ_r < TABLE_SLOTS[AW:0]) begin
            wr_en   = 1'b1;
            wr_new  = 1'b1;
            wr_cnt  = 32'd1;
            occ_nxt = occ_r + 1'b1;
            res_nxt = '{kmer_code: win_r, count: 32'd1, entry_present: 1'b1,
                        status: ST_COUNTED};
          end else begin
            res_nxt = '{kmer_code: win_r, count: '0, entry_present: 1'b0, status: ST_FULL};
          end
        end else if (rd_key_r == win_r) begin
          wr_en   = 1'b1;
          wr_cnt  = (rd_cnt_r == COUNT_MAX) ? rd_cnt_r : rd_cnt_r + 32'd1;
          res_nxt = '{kmer_code: win_r, count: wr_cnt, entry_present: 1'b1,
                      status: ST_COUNTED};
        end else begin
          res_nxt  = '{kmer_code: win_r, count: '0, entry_present: 1'b0, status: ST_FULL};
          idx_nxt  = idx_r + 1'b1;
          pcnt_nxt = pcnt_r + 1'b1;
        end
      end
      S_RDOUT: begin
        res_nxt = '{kmer_code: rd_used_r ? rd_key_r : '0,
                    count: rd_used_r ? rd_cnt_r : '0,
                    entry_present: rd_used_r, status: ST_READOUT};
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        if (!item_r.mode && item_r.last_of_read) begin
          win_nxt  = '0;
          fill_nxt = '0;
          bad_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
    if (cfg_we) begin
      win_nxt  = '0;
      fill_nxt = '0;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      k_r        <= 5'd8;
      win_r      <= '0;
      fill_r     <= '0;
      bad_r      <= 1'b0;
      occ_r      <= '0;
      ov_r       <= 1'b0;
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      bad_r   <= bad_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        if (cfg_wdata == '0) k_r <= 5'd1;
        else if (cfg_wdata > K_W'(MAX_K)) k_r <= K_W'(MAX_K);
        else k_r <= cfg_wdata;
      end
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == TABLE_SLOTS[AW:0] - 1) clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    hcnt_r <= hcnt_nxt;
    idx_r  <= idx_nxt;
    pcnt_r <= pcnt_nxt;
    res_r  <= res_nxt;
  end

  // table memories
  logic [AW-1:0] rd_addr;
  assign rd_addr = (state_r == S_IDLE) ? AW'(in_item.slot_index) : idx_r;

  always_ff @(posedge clk) begin
    if (clearing_r) used_mem[clr_r[AW-1:0]] <= 1'b0;
    else if (wr_en && wr_new) used_mem[idx_r] <= 1'b1;
    rd_used_r <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[idx_r] <= win_r;
      cnt_mem[idx_r] <= wr_cnt;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_cnt_r <= cnt_mem[rd_addr];
  end

  assign out_valid = ov_r;
  assign out_item  = res_r;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(state_r == S_IDLE))
    else $error("result strobe without work");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> busy)
    else $error("not busy during clear");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= TABLE_SLOTS[AW:0])
    else $error("occupancy overflow");

endmodule
